@@ sv/fsla_pkg.sv @@
package fsla_pkg;

  localparam int POOL_SLOTS = 128;
  localparam int SLOT_W     = $clog2(POOL_SLOTS);
  localparam int CNT_W      = $clog2(POOL_SLOTS + 1);
  localparam int ITEM_CNT_W = 8;

  typedef enum logic {
    KIND_ALLOC   = 1'b0,
    KIND_RELEASE = 1'b1
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_BAD_COUNT = 2'd2,
    ST_NOT_USED  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EVAL = 2'b10
  } state_t;

  // access to the slot memory: one read and one write port
  typedef struct packed {
    logic              rd_en;
    logic [SLOT_W-1:0] rd_addr;
    logic              wr_en;
    logic [SLOT_W-1:0] wr_addr;
    logic              wr_busy;
    logic [SLOT_W-1:0] wr_link;
  } mem_req_t;

  typedef struct packed {
    logic              busy;
    logic [SLOT_W-1:0] link;
  } mem_rsp_t;

endpackage

@@ sv/fsla_if.sv @@
interface fsla_req_if import fsla_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic                  kind;
  logic [SLOT_W-1:0]     slot_index;
  logic [ITEM_CNT_W-1:0] item_count;

  modport source (output valid, kind, slot_index, item_count, input ready);
  modport sink (input valid, kind, slot_index, item_count, output ready);
endinterface

interface fsla_rsp_if import fsla_pkg::*;;
  logic              valid;
  logic              ready;
  logic [SLOT_W-1:0] granted_slot;
  logic [1:0]        status;
  logic [CNT_W-1:0]  allocated_count;
  logic [CNT_W-1:0]  available_count;

  modport source (output valid, granted_slot, status, allocated_count, available_count,
                  input ready);
  modport sink (input valid, granted_slot, status, allocated_count, available_count,
                output ready);
endinterface

@@ sv/fsla_slot_mem.sv @@
module fsla_slot_mem import fsla_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  mem_req_t mreq,
  output mem_rsp_t mrsp
);

  // each word holds {busy, link}
  logic [SLOT_W:0]     mem [POOL_SLOTS];
  logic [POOL_SLOTS-1:0] written;
  logic [SLOT_W:0]     rd_word;
  logic                rd_written;
  logic [SLOT_W-1:0]   rd_addr_q;

  always_ff @(posedge clk) begin
    if (mreq.wr_en) begin
      mem[mreq.wr_addr] <= {mreq.wr_busy, mreq.wr_link};
    end
    if (mreq.rd_en) begin
      rd_word    <= mem[mreq.rd_addr];
      rd_written <= written[mreq.rd_addr];
      rd_addr_q  <= mreq.rd_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
    end else if (mreq.wr_en) begin
      written[mreq.wr_addr] <= 1'b1;
    end
  end

  // an entry never written reads as free, linked to the slot just below
  always_comb begin
    if (rd_written) begin
      mrsp.busy = rd_word[SLOT_W];
      mrsp.link = rd_word[SLOT_W-1:0];
    end else begin
      mrsp.busy = 1'b0;
      mrsp.link = (rd_addr_q == '0) ? '0 : rd_addr_q - 1'b1;
    end
  end

endmodule

@@ sv/fixed_slot_free_list_allocator.sv @@
// Fixed-size slot pool with a LIFO free list. Each request word on req either
// allocates a slot (kind 0) or releases slot_index (kind 1); item_count must be
// exactly one. Every request yields one response word with the granted slot
// (zero unless an allocate succeeded), a status (ok, pool empty, count not one,
// slot not in use) and the in-use and free counts after the request. After reset
// all slots are free and are granted from the highest index downward; no
// clearing pass is needed, so the first request is taken straight after reset.
// A request first reads the link and busy word of the slot from the synchronous
// slot memory, then evaluates and writes it back. A new request is taken only
// after the last one has been evaluated; a pending response word that has not
// been taken holds the evaluate state.
module fixed_slot_free_list_allocator import fsla_pkg::*; (
  input logic       clk,
  input logic       rst,
  fsla_req_if.sink  req,
  fsla_rsp_if.source rsp
);

  state_t            state;
  logic              req_kind;
  logic [SLOT_W-1:0] req_slot;
  logic              req_count_ok;
  logic [SLOT_W-1:0] free_head;
  logic [CNT_W-1:0]  used_slots;

  logic [SLOT_W-1:0] free_head_next;
  logic [CNT_W-1:0]  used_slots_next;
  status_t           status_next;
  logic              accept;
  logic              out_free;
  logic              advance;
  logic              is_alloc;
  logic              ok;
  mem_req_t          mreq;
  mem_rsp_t          mrsp;

  fsla_slot_mem u_mem (
    .clk  (clk),
    .rst  (rst),
    .mreq (mreq),
    .mrsp (mrsp)
  );

  assign req.ready = (state == S_IDLE) && !rst;
  assign accept    = req.valid && req.ready;
  assign out_free  = !rsp.valid || rsp.ready;
  assign advance   = (state == S_EVAL) && out_free;
  assign is_alloc  = (req_kind == KIND_ALLOC);

  always_comb begin
    if (!req_count_ok) begin
      status_next = ST_BAD_COUNT;
    end else if (is_alloc) begin
      status_next = (used_slots >= CNT_W'(POOL_SLOTS)) ? ST_EMPTY : ST_OK;
    end else if (CNT_W'(req_slot) >= CNT_W'(POOL_SLOTS) || !mrsp.busy) begin
      status_next = ST_NOT_USED;
    end else begin
      status_next = ST_OK;
    end
  end

  assign ok = (status_next == ST_OK);

  always_comb begin
    free_head_next  = free_head;
    used_slots_next = used_slots;
    if (ok) begin
      if (is_alloc) begin
        free_head_next  = mrsp.link;
        used_slots_next = used_slots + 1'b1;
      end else begin
        free_head_next  = req_slot;
        used_slots_next = used_slots - 1'b1;
      end
    end
  end

  // read the head on allocate, the named slot on release
  always_comb begin
    mreq.rd_en   = accept;
    mreq.rd_addr = (req.kind == KIND_RELEASE) ? req.slot_index : free_head;
    mreq.wr_en   = advance && ok;
    mreq.wr_addr = is_alloc ? free_head : req_slot;
    mreq.wr_busy = is_alloc;
    mreq.wr_link = is_alloc ? mrsp.link : free_head;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      free_head  <= SLOT_W'(POOL_SLOTS - 1);
      used_slots <= '0;
      rsp.valid  <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_EVAL;
          end
        end
        S_EVAL: begin
          if (advance) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
      if (advance) begin
        free_head  <= free_head_next;
        used_slots <= used_slots_next;
        rsp.valid  <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_kind     <= req.kind;
      req_slot     <= req.slot_index;
      req_count_ok <= (req.item_count == ITEM_CNT_W'(1));
    end
    if (advance) begin
      rsp.granted_slot    <= (is_alloc && ok) ? free_head : '0;
      rsp.status          <= status_next;
      rsp.allocated_count <= used_slots_next;
      rsp.available_count <= CNT_W'(POOL_SLOTS) - used_slots_next;
    end
  end

  a_used_bound: assert property (@(posedge clk) disable iff (rst)
    used_slots <= CNT_W'(POOL_SLOTS))
    else $error("in-use count exceeds pool size");

  a_eval_emits: assert property (@(posedge clk) disable iff (rst)
    advance |=> rsp.valid && state == S_IDLE)
    else $error("evaluated request did not produce a response word");

  a_counts_sum: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> ({1'b0, rsp.allocated_count} + {1'b0, rsp.available_count})
                  == (CNT_W + 1)'(POOL_SLOTS))
    else $error("in-use and free counts do not cover the pool");

  a_grant_only_ok: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.status != ST_OK |-> rsp.granted_slot == '0)
    else $error("slot granted on a failed request");

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
  import fsla_pkg::*;

  typedef struct {
    kind_t                 kind;
    logic [SLOT_W-1:0]     slot_index;
    logic [ITEM_CNT_W-1:0] item_count;
  } req_word_t;

  typedef struct {
    logic [SLOT_W-1:0] granted_slot;
    status_t           status;
    logic [CNT_W-1:0]  allocated_count;
    logic [CNT_W-1:0]  available_count;
  } rsp_word_t;

  typedef struct {
    req_word_t word;
    bit        typed;
    rsp_word_t result;
  } directed_row_t;

  typedef enum {
    MODE_FILL,
    MODE_DRAIN,
    MODE_MIX
  } traffic_mode_t;

  logic clk;
  logic rst;

  fsla_req_if req_bus ();
  fsla_rsp_if rsp_bus ();

  fixed_slot_free_list_allocator i_dut (
    .clk (clk),
    .rst (rst),
    .req (req_bus),
    .rsp (rsp_bus)
  );

  // pool model: LIFO free list plus occupancy
  logic [SLOT_W-1:0] free_top;
  logic [SLOT_W-1:0] next_free [POOL_SLOTS];
  bit                in_use [POOL_SLOTS];
  int                in_use_count;

  rsp_word_t     pending_rsp [$];
  directed_row_t directed [$];
  int            errors;
  int            words_sent;
  bit            req_no_gap;
  bit            rsp_no_stall;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic rsp_word_t apply_request(req_word_t w);
    rsp_word_t r;
    r.granted_slot = '0;
    r.status       = ST_OK;
    if (w.item_count != 1) begin
      r.status = ST_BAD_COUNT;
    end else if (w.kind == KIND_ALLOC) begin
      if (in_use_count >= POOL_SLOTS) begin
        r.status = ST_EMPTY;
      end else begin
        r.granted_slot         = free_top;
        free_top               = next_free[free_top];
        in_use[r.granted_slot] = 1'b1;
        in_use_count++;
      end
    end else begin
      if (int'(w.slot_index) >= POOL_SLOTS || !in_use[w.slot_index]) begin
        r.status = ST_NOT_USED;
      end else begin
        next_free[w.slot_index] = free_top;
        free_top                = w.slot_index;
        in_use[w.slot_index]    = 1'b0;
        if (in_use_count > 0) in_use_count--;
      end
    end
    r.allocated_count = CNT_W'(in_use_count);
    r.available_count = CNT_W'(POOL_SLOTS - in_use_count);
    return r;
  endfunction

  // pick the n-th slot whose occupancy matches want_busy
  function automatic logic [SLOT_W-1:0] pick_slot(bit want_busy);
    int                target;
    int                seen;
    int                pool;
    logic [SLOT_W-1:0] found;
    pool   = want_busy ? in_use_count : POOL_SLOTS - in_use_count;
    target = $urandom_range(0, pool - 1);
    seen   = 0;
    found  = '0;
    for (int i = 0; i < POOL_SLOTS; i++) begin
      if (in_use[i] == want_busy) begin
        if (seen == target) found = SLOT_W'(i);
        seen++;
      end
    end
    return found;
  endfunction

  function automatic req_word_t release_word(bit stray);
    req_word_t w;
    w.kind       = KIND_RELEASE;
    w.item_count = ITEM_CNT_W'(1);
    if (in_use_count == 0) stray = 1'b1;
    if (in_use_count == POOL_SLOTS) stray = 1'b0;
    w.slot_index = pick_slot(!stray);
    return w;
  endfunction

  function automatic req_word_t next_request(traffic_mode_t mode);
    req_word_t w;
    int        roll;
    roll = $urandom_range(0, 99);
    if (roll < 10) begin
      // noise: any kind, any slot, any count
      w.kind       = kind_t'($urandom_range(0, 1));
      w.slot_index = SLOT_W'($urandom);
      w.item_count = ITEM_CNT_W'($urandom);
      return w;
    end
    w.kind       = KIND_ALLOC;
    w.slot_index = SLOT_W'($urandom);
    w.item_count = ITEM_CNT_W'(1);
    case (mode)
      MODE_FILL: begin
      end
      MODE_DRAIN: begin
        w = release_word(roll < 14);
      end
      default: begin
        if (roll >= 55) w = release_word(roll >= 90);
      end
    endcase
    return w;
  endfunction

  function automatic void add_row(kind_t k, int slot, int cnt, bit typed, int g = 0,
                                  status_t s = ST_OK, int used = 0, int avail = 0);
    directed_row_t row;
    row.word.kind              = k;
    row.word.slot_index        = SLOT_W'(slot);
    row.word.item_count        = ITEM_CNT_W'(cnt);
    row.typed                  = typed;
    row.result.granted_slot    = SLOT_W'(g);
    row.result.status          = s;
    row.result.allocated_count = CNT_W'(used);
    row.result.available_count = CNT_W'(avail);
    directed.insert(directed.size(), row);
  endfunction

  // enter and leave at a falling edge
  task automatic send_word(req_word_t w, bit typed, rsp_word_t typed_result);
    int        gap;
    rsp_word_t predicted;
    gap = req_no_gap ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      req_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_bus.kind       <= w.kind;
    req_bus.slot_index <= w.slot_index;
    req_bus.item_count <= w.item_count;
    req_bus.valid      <= 1'b1;
    @(posedge clk);
    while (!req_bus.ready) @(posedge clk);
    predicted = apply_request(w);
    pending_rsp.insert(pending_rsp.size(), typed ? typed_result : predicted);
    words_sent++;
    @(negedge clk);
  endtask

  task automatic send_random(traffic_mode_t mode);
    rsp_word_t unused;
    unused = '{granted_slot: '0, status: ST_OK, allocated_count: '0,
               available_count: '0};
    send_word(next_request(mode), 1'b0, unused);
  endtask

  task automatic hold_until_drained();
    if (pending_rsp.size() != 0) begin
      req_bus.valid <= 1'b0;
      while (pending_rsp.size() != 0) @(negedge clk);
    end
  endtask

  initial begin
    traffic_mode_t mode;
    int            len;
    int            settle;

    rst                = 1'b1;
    req_bus.valid      = 1'b0;
    req_bus.kind       = KIND_ALLOC;
    req_bus.slot_index = '0;
    req_bus.item_count = '0;
    errors             = 0;
    words_sent         = 0;
    req_no_gap         = 1'b0;
    rsp_no_stall       = 1'b0;

    free_top     = SLOT_W'(POOL_SLOTS - 1);
    in_use_count = 0;
    next_free[0] = '0;
    for (int i = 1; i < POOL_SLOTS; i++) next_free[i] = SLOT_W'(i - 1);
    for (int i = 0; i < POOL_SLOTS; i++) in_use[i] = 1'b0;

    add_row(KIND_ALLOC,   0,   1,   1'b1, 127, ST_OK,        1, 127);
    add_row(KIND_ALLOC,   0,   1,   1'b1, 126, ST_OK,        2, 126);
    add_row(KIND_RELEASE, 127, 1,   1'b1, 0,   ST_OK,        1, 127);
    // double free
    add_row(KIND_RELEASE, 127, 1,   1'b1, 0,   ST_NOT_USED,  1, 127);
    add_row(KIND_ALLOC,   0,   0,   1'b1, 0,   ST_BAD_COUNT, 1, 127);
    add_row(KIND_ALLOC,   0,   255, 1'b1, 0,   ST_BAD_COUNT, 1, 127);
    // count check wins over a valid release
    add_row(KIND_RELEASE, 126, 2,   1'b1, 0,   ST_BAD_COUNT, 1, 127);
    add_row(KIND_RELEASE, 0,   1,   1'b1, 0,   ST_NOT_USED,  1, 127);
    // slot_index ignored on allocate; last released comes back first
    add_row(KIND_ALLOC,   127, 1,   1'b1, 127, ST_OK,        2, 126);
    add_row(KIND_RELEASE, 126, 1,   1'b0);
    add_row(KIND_ALLOC,   0,   1,   1'b0);
    add_row(KIND_RELEASE, 127, 128, 1'b1, 0,   ST_BAD_COUNT, 2, 126);
    add_row(KIND_RELEASE, 126, 1,   1'b0);
    add_row(KIND_RELEASE, 127, 1,   1'b0);
    add_row(KIND_RELEASE, 127, 1,   1'b1, 0,   ST_NOT_USED,  0, 128);
    add_row(KIND_RELEASE, 0,   255, 1'b1, 0,   ST_BAD_COUNT, 0, 128);
    add_row(KIND_ALLOC,   0,   1,   1'b0);
    add_row(KIND_ALLOC,   0,   1,   1'b0);
    add_row(KIND_ALLOC,   85,  1,   1'b0);
    add_row(KIND_RELEASE, 64,  1,   1'b0);
    add_row(KIND_ALLOC,   0,   254, 1'b1, 0,   ST_BAD_COUNT, 3, 125);
    add_row(KIND_RELEASE, 1,   1,   1'b0);
    add_row(KIND_ALLOC,   42,  1,   1'b0);

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (directed[i]) send_word(directed[i].word, directed[i].typed, directed[i].result);
    hold_until_drained();

    // fill to empty, then drain completely, then free-running phases
    mode = MODE_FILL;
    while (words_sent < 560) begin
      req_no_gap   = ($urandom_range(0, 3) == 0);
      rsp_no_stall = ($urandom_range(0, 3) == 0);
      case (mode)
        MODE_FILL: begin
          while (in_use_count < POOL_SLOTS) send_random(MODE_FILL);
          repeat (3) send_random(MODE_FILL);
        end
        MODE_DRAIN: begin
          while (in_use_count > 0) send_random(MODE_DRAIN);
          repeat (2) send_random(MODE_DRAIN);
        end
        default: begin
          len = $urandom_range(20, 80);
          repeat (len) send_random(MODE_MIX);
        end
      endcase
      if ($urandom_range(0, 1) == 0) hold_until_drained();
      if (mode == MODE_FILL && words_sent < 200) mode = MODE_DRAIN;
      else mode = traffic_mode_t'($urandom_range(0, 2));
    end
    req_bus.valid <= 1'b0;

    settle = 0;
    while (pending_rsp.size() != 0 && settle < 2000) begin
      @(posedge clk);
      settle++;
    end
    repeat (10) @(posedge clk);
    if (pending_rsp.size() != 0) begin
      errors++;
      $error("%0d response words never arrived", pending_rsp.size());
    end
    if (errors == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

  // response side back-pressure
  initial begin
    int stall;
    rsp_bus.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      stall = rsp_no_stall ? 0 : $urandom_range(0, 12);
      if (stall > 0) begin
        rsp_bus.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      rsp_bus.ready <= 1'b1;
      @(posedge clk);
      while (!rsp_bus.valid) @(posedge clk);
      @(negedge clk);
    end
  end

  always @(posedge clk) begin : rsp_check
    rsp_word_t want;
    if (!rst && rsp_bus.valid && rsp_bus.ready) begin
      if (pending_rsp.size() == 0) begin
        errors++;
        $error("response word with nothing pending");
      end else begin
        want = pending_rsp.pop_front();
        if (rsp_bus.granted_slot !== want.granted_slot) begin
          errors++;
          $error("granted_slot: expected %0d, got %0d", want.granted_slot,
                 rsp_bus.granted_slot);
        end
        if (rsp_bus.status !== want.status) begin
          errors++;
          $error("status: expected %0d, got %0d", want.status, rsp_bus.status);
        end
        if (rsp_bus.allocated_count !== want.allocated_count) begin
          errors++;
          $error("allocated_count: expected %0d, got %0d", want.allocated_count,
                 rsp_bus.allocated_count);
        end
        if (rsp_bus.available_count !== want.available_count) begin
          errors++;
          $error("available_count: expected %0d, got %0d", want.available_count,
                 rsp_bus.available_count);
        end
      end
    end
  end

  initial begin
    #3_000_000;
    $display("tb_top: errors");
    $finish;
  end

endmodule

@@ fixed_slot_free_list_allocator.f @@
sv/fsla_pkg.sv
sv/fsla_if.sv
sv/fsla_slot_mem.sv
sv/fixed_slot_free_list_allocator.sv
bench/tb_top.sv
